>>> sv/lfs_pkg.sv
// shared types, reset values and the sensor pattern table for the line follower steering block
`default_nettype none

package lfs_pkg;

    localparam int SENSOR_W = 8;
    localparam int SPEED_W  = 7;
    localparam int GAIN_W   = 5;
    localparam int ERR_W    = 4;
    localparam int DIFF_W   = 5;
    localparam int STEER_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int M_TDATA_W  = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_CEIL    = 3'd5;

    localparam logic [SPEED_W-1:0] RST_CRUISE_SPD  = 7'd20;
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 5'd5;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = 5'd7;
    localparam logic [SPEED_W-1:0] RST_STEER_LIMIT = 7'd25;
    localparam logic [SPEED_W-1:0] RST_SPD_FLOOR   = 7'd5;
    localparam logic [SPEED_W-1:0] RST_SPD_CEIL    = 7'd40;

    // number of repeats after the first read that make a pattern stable
    localparam logic [1:0] STABLE_REPEATS = 2'd2;

    typedef struct packed {
        logic [SPEED_W-1:0] cruise_spd;
        logic [GAIN_W-1:0]  prop_gain_half;
        logic [GAIN_W-1:0]  deriv_gain_half;
        logic [SPEED_W-1:0] steer_limit;
        logic [SPEED_W-1:0] spd_floor;
        logic [SPEED_W-1:0] spd_ceil;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
    } track_item_t;

    typedef struct packed {
        logic                    hit;
        logic signed [ERR_W-1:0] err;
    } map_t;

    function automatic map_t map_pattern(input logic [SENSOR_W-1:0] pat);
        map_t m;
        m.hit = 1'b1;
        m.err = 4'sd0;
        case (pat)
            8'd0, 8'd24, 8'd60, 8'd126: m.err = 4'sd0;
            8'd8, 8'd16: m.err = 4'sd1;
            8'd32, 8'd48, 8'd56: m.err = 4'sd2;
            8'd64, 8'd96, 8'd120, 8'd124: m.err = 4'sd4;
            8'd128, 8'd160, 8'd192, 8'd224,
            8'd240, 8'd248, 8'd252, 8'd254: m.err = 4'sd6;
            8'd4, 8'd12, 8'd28: m.err = -4'sd2;
            8'd2, 8'd6, 8'd14, 8'd30, 8'd62: m.err = -4'sd4;
            8'd1, 8'd3, 8'd7, 8'd15,
            8'd31, 8'd63, 8'd125: m.err = -4'sd6;
            default: m.hit = 1'b0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> sv/lfs_track.sv
// debounce of the sensor pattern, error lookup and pd difference, one registered item per transfer
`default_nettype none

module lfs_track
    import lfs_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [SENSOR_W-1:0] s_sensor_bits,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output track_item_t              out_item
);

    logic [SENSOR_W-1:0]     prev_pattern_reg, prev_pattern_next;
    logic [1:0]              stable_count_reg, stable_count_next;
    // the error used by the last pd step always equals the held error
    logic signed [ERR_W-1:0] held_err_reg, held_err_next;
    logic                    valid_reg;
    track_item_t             item_reg, item_next;
    logic                    accept;
    logic [1:0]              count_inc;
    map_t                    lookup;
    logic signed [DIFF_W-1:0] err_ext, prior_ext;

    assign s_tready = !valid_reg || out_ready;
    assign accept   = s_tvalid && s_tready;
    assign lookup   = map_pattern(s_sensor_bits);
    assign count_inc = stable_count_reg + 2'd1;

    always_comb begin
        prev_pattern_next = prev_pattern_reg;
        stable_count_next = stable_count_reg;
        held_err_next     = held_err_reg;
        if (s_sensor_bits == prev_pattern_reg) begin
            if (count_inc >= STABLE_REPEATS) begin
                stable_count_next = 2'd0;
                if (lookup.hit) begin
                    held_err_next = lookup.err;
                end
            end else begin
                stable_count_next = count_inc;
            end
        end else begin
            prev_pattern_next = s_sensor_bits;
            stable_count_next = 2'd0;
        end
    end

    assign err_ext   = {held_err_next[ERR_W-1], held_err_next};
    assign prior_ext = {held_err_reg[ERR_W-1], held_err_reg};

    always_comb begin
        item_next.err = held_err_next;
        if (held_err_reg == 4'sd0 && held_err_next != 4'sd0) begin
            // halve toward zero on the first step away from center
            item_next.diff = (err_ext + $signed({4'b0, err_ext[DIFF_W-1]})) >>> 1;
        end else begin
            item_next.diff = err_ext - prior_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pattern_reg <= '0;
            stable_count_reg <= 2'd0;
            held_err_reg     <= 4'sd0;
            valid_reg        <= 1'b0;
        end else begin
            if (s_tready) begin
                valid_reg <= s_tvalid;
            end
            if (accept) begin
                prev_pattern_reg <= prev_pattern_next;
                stable_count_reg <= stable_count_next;
                held_err_reg     <= held_err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stable_count_reg != 2'd3)
        else $error("stable count reached three");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_err_reg <= 4'sd6 && held_err_reg >= -4'sd6)
        else $error("held error out of range");

    a_new_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_sensor_bits != prev_pattern_reg |=>
            stable_count_reg == 2'd0 && held_err_reg == $past(held_err_reg))
        else $error("new pattern did not restart debounce");

endmodule

`default_nettype wire

>>> sv/lfs_steer.sv
// pd sum, saturation and wheel speed clamp into the result register
`default_nettype none

module lfs_steer
    import lfs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire track_item_t in_item,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [SPEED_W-1:0]        m_left_cmd,
    output logic [SPEED_W-1:0]        m_right_cmd,
    output logic signed [ERR_W-1:0]   m_line_error,
    output logic signed [STEER_W-1:0] m_steer
);

    localparam int SUM_W = 11;

    logic                     m_valid_reg;
    logic [SPEED_W-1:0]        left_reg, left_next;
    logic [SPEED_W-1:0]        right_reg, right_next;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [STEER_W-1:0] steer_reg, steer_next;

    logic signed [SUM_W-1:0] p_term, d_term, pd_sum, pd_half, lim, sat;
    logic signed [SUM_W-1:0] base_s, left_raw, right_raw;

    assign in_ready = !m_valid_reg || m_tready;

    assign p_term = $signed({6'b0, cfg.prop_gain_half})
                  * $signed({{(SUM_W-ERR_W){in_item.err[ERR_W-1]}}, in_item.err});
    assign d_term = $signed({6'b0, cfg.deriv_gain_half})
                  * $signed({{(SUM_W-DIFF_W){in_item.diff[DIFF_W-1]}}, in_item.diff});
    assign pd_sum  = p_term + d_term;
    // divide by two, truncating toward zero
    assign pd_half = (pd_sum + $signed({10'b0, pd_sum[SUM_W-1]})) >>> 1;
    assign lim     = $signed({4'b0, cfg.steer_limit});

    always_comb begin
        sat = pd_half;
        if (pd_half > lim) begin
            sat = lim;
        end
        if (pd_half < -lim) begin
            sat = -lim;
        end
    end

    assign steer_next = sat[STEER_W-1:0];
    assign base_s     = $signed({4'b0, cfg.cruise_spd});
    assign left_raw   = base_s - sat;
    assign right_raw  = base_s + sat;

    function automatic logic [SPEED_W-1:0] clamp_speed(
        input logic signed [SUM_W-1:0] v,
        input logic [SPEED_W-1:0]      lo,
        input logic [SPEED_W-1:0]      hi
    );
        logic signed [SUM_W-1:0] r;
        r = v;
        if (r < $signed({4'b0, lo})) begin
            r = $signed({4'b0, lo});
        end
        if (r > $signed({4'b0, hi})) begin
            r = $signed({4'b0, hi});
        end
        return r[SPEED_W-1:0];
    endfunction

    assign left_next  = clamp_speed(left_raw, cfg.spd_floor, cfg.spd_ceil);
    assign right_next = clamp_speed(right_raw, cfg.spd_floor, cfg.spd_ceil);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            left_reg  <= left_next;
            right_reg <= right_next;
            err_reg   <= in_item.err;
            steer_reg <= steer_next;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_left_cmd   = left_reg;
    assign m_right_cmd  = right_reg;
    assign m_line_error = err_reg;
    assign m_steer      = steer_reg;

endmodule

`default_nettype wire

>>> sv/line_follow_steering_pd.sv
// Line follower PD steering: each s_ transfer carries one 8-bit sensor pattern (bit 7 leftmost)
// and yields exactly one m_ transfer with left/right wheel speeds, the held tracking error and
// the saturated steering value. A pattern updates the error only on its third read in a row;
// unknown stable patterns keep the previous error. Items pass a tracking stage, then the pd
// multiply/saturate/clamp stage into the result register, one item per cycle unless the output
// stalls; the input keeps accepting while a result waits if the stages hold room. The user
// writes configuration registers via cfg_wr_en/cfg_index/cfg_wdata only while idle, unchecked.
`default_nettype none

module line_follow_steering_pd
    import lfs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SENSOR_W-1:0]   s_tdata,   // [7:0] sensor_bits
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [6:0] left_cmd, [13:7] right_cmd, [17:14] line_error, [25:18] steer, [31:26] zero
    output logic [M_TDATA_W-1:0]       m_tdata
);

    cfg_t        cfg_reg;
    logic        mid_valid, mid_ready;
    track_item_t mid_item;

    logic [SPEED_W-1:0]        left_cmd, right_cmd;
    logic signed [ERR_W-1:0]   line_error;
    logic signed [STEER_W-1:0] steer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cruise_spd      <= RST_CRUISE_SPD;
            cfg_reg.prop_gain_half  <= RST_PROP_GAIN;
            cfg_reg.deriv_gain_half <= RST_DERIV_GAIN;
            cfg_reg.steer_limit     <= RST_STEER_LIMIT;
            cfg_reg.spd_floor       <= RST_SPD_FLOOR;
            cfg_reg.spd_ceil        <= RST_SPD_CEIL;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CRUISE_SPD:  cfg_reg.cruise_spd      <= cfg_wdata;
                CFG_PROP_GAIN:   cfg_reg.prop_gain_half  <= cfg_wdata[GAIN_W-1:0];
                CFG_DERIV_GAIN:  cfg_reg.deriv_gain_half <= cfg_wdata[GAIN_W-1:0];
                CFG_STEER_LIMIT: cfg_reg.steer_limit     <= cfg_wdata;
                CFG_SPD_FLOOR:   cfg_reg.spd_floor       <= cfg_wdata;
                CFG_SPD_CEIL:    cfg_reg.spd_ceil        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lfs_track u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_sensor_bits (s_tdata),
        .out_valid     (mid_valid),
        .out_ready     (mid_ready),
        .out_item      (mid_item)
    );

    lfs_steer u_steer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (mid_valid),
        .in_ready      (mid_ready),
        .in_item       (mid_item),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_left_cmd    (left_cmd),
        .m_right_cmd   (right_cmd),
        .m_line_error  (line_error),
        .m_steer       (steer)
    );

    assign m_tdata = {6'b0, steer, line_error, right_cmd, left_cmd};

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the line follower pd steering block
module testbench;
    import lfs_pkg::*;

    localparam int LIMIT       = 1000000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 156;
    localparam int HOLD_CYCLES = 300;
    localparam int N_DIR       = 21;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic [5:0]                pad;
        logic signed [STEER_W-1:0] steer;
        logic signed [ERR_W-1:0]   err;
        logic [SPEED_W-1:0]        right;
        logic [SPEED_W-1:0]        left;
    } wheel_cmd_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] pat;
        logic                typed;
        wheel_cmd_t          res;
    } dir_row_t;

    localparam wheel_cmd_t NO_CHECK = '0;
    localparam wheel_cmd_t CRUISE   = '{pad: 6'd0, steer: 8'sd0, err: 4'sd0,
                                        right: 7'd20, left: 7'd20};
    // full left sensor at reset gains: steer saturates at the limit
    localparam wheel_cmd_t SAT_POS  = '{pad: 6'd0, steer: 8'sd25, err: 4'sd6,
                                        right: 7'd40, left: 7'd5};
    localparam wheel_cmd_t SAT_NEG  = '{pad: 6'd0, steer: -8'sd25, err: -4'sd6,
                                        right: 7'd5, left: 7'd40};

    dir_row_t dir_tab [N_DIR] = '{
        '{8'h00, 1'b1, CRUISE},    // matches reset pattern, first repeat
        '{8'h00, 1'b1, CRUISE},    // stable, error stays zero
        '{8'hFF, 1'b1, CRUISE},
        '{8'hFF, 1'b1, CRUISE},
        '{8'hFF, 1'b1, CRUISE},    // stable but unknown, error held
        '{8'h80, 1'b1, CRUISE},
        '{8'h80, 1'b1, CRUISE},
        '{8'h80, 1'b1, SAT_POS},   // first step away from zero halves the diff
        '{8'h80, 1'b0, NO_CHECK},
        '{8'h01, 1'b0, NO_CHECK},
        '{8'h01, 1'b0, NO_CHECK},
        '{8'h01, 1'b1, SAT_NEG},   // full swing, saturates low
        '{8'hAA, 1'b0, NO_CHECK},
        '{8'hAA, 1'b0, NO_CHECK},
        '{8'hAA, 1'b0, NO_CHECK},
        '{8'h18, 1'b0, NO_CHECK},
        '{8'h18, 1'b0, NO_CHECK},
        '{8'h18, 1'b0, NO_CHECK},
        '{8'h10, 1'b0, NO_CHECK},
        '{8'h10, 1'b0, NO_CHECK},
        '{8'h10, 1'b0, NO_CHECK}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CRUISE_SPD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SENSOR_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    line_follow_steering_pd DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    // predictor state
    cfg_t                cur_cfg;
    logic [SENSOR_W-1:0] last_pat;
    logic [1:0]          repeat_cnt;
    int                  hold_err;
    int                  pd_err;

    wheel_cmd_t wheel_q [$];
    int         fail_cnt = 0;
    int         cycle_cnt = 0;
    bit         tx_quiet = 1'b0;
    bit         rx_quiet = 1'b0;
    bit         hold_req = 1'b0;
    logic       rx_hold = 1'b0;
    int         rx_stall_left = 0;

    function automatic bit sensor_error(input logic [SENSOR_W-1:0] pat, output int e);
        sensor_error = 1'b1;
        e = 0;
        case (pat)
            8'h00, 8'h18, 8'h3C, 8'h7E: e = 0;
            8'h08, 8'h10: e = 1;
            8'h20, 8'h30, 8'h38: e = 2;
            8'h40, 8'h60, 8'h78, 8'h7C: e = 4;
            8'h80, 8'hA0, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE: e = 6;
            8'h04, 8'h0C, 8'h1C: e = -2;
            8'h02, 8'h06, 8'h0E, 8'h1E, 8'h3E: e = -4;
            8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7D: e = -6;
            default: sensor_error = 1'b0;
        endcase
    endfunction

    function automatic int wheel_clamp(input int v);
        int r;
        r = v;
        if (r < int'(cur_cfg.spd_floor)) r = int'(cur_cfg.spd_floor);
        if (r > int'(cur_cfg.spd_ceil)) r = int'(cur_cfg.spd_ceil);
        return r;
    endfunction

    // advances the debounce and pd state by one sample
    function automatic wheel_cmd_t steer_predict(input logic [SENSOR_W-1:0] pat);
        wheel_cmd_t c;
        int mapped, d, raw, lim;
        if (pat == last_pat) begin
            repeat_cnt = repeat_cnt + 2'd1;
            if (repeat_cnt >= 2'd2) begin
                if (sensor_error(pat, mapped)) hold_err = mapped;
                repeat_cnt = 2'd0;
            end
        end else begin
            last_pat = pat;
            repeat_cnt = 2'd0;
        end
        d = hold_err - pd_err;
        if (pd_err == 0 && hold_err != 0) d = hold_err / 2;
        raw = (int'(cur_cfg.prop_gain_half) * hold_err
               + int'(cur_cfg.deriv_gain_half) * d) / 2;
        lim = int'(cur_cfg.steer_limit);
        if (raw > lim) raw = lim;
        if (raw < -lim) raw = -lim;
        pd_err = hold_err;
        c.pad   = '0;
        c.steer = STEER_W'(raw);
        c.err   = ERR_W'(hold_err);
        c.left  = SPEED_W'(wheel_clamp(int'(cur_cfg.cruise_spd) - raw));
        c.right = SPEED_W'(wheel_clamp(int'(cur_cfg.cruise_spd) + raw));
        return c;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [SENSOR_W-1:0] known_pattern();
        logic [SENSOR_W-1:0] pat;
        int e;
        do pat = SENSOR_W'($urandom_range(0, 255)); while (!sensor_error(pat, e));
        return pat;
    endfunction

    function automatic cfg_t phase_cfg(input int ph);
        cfg_t c;
        case (ph)
            0: c = '{cruise_spd: 7'd64, prop_gain_half: 5'd8, deriv_gain_half: 5'd12,
                     steer_limit: 7'd40, spd_floor: 7'd10, spd_ceil: 7'd120};
            1: c = '0;
            2: c = '{cruise_spd: 7'd127, prop_gain_half: 5'd31, deriv_gain_half: 5'd31,
                     steer_limit: 7'd127, spd_floor: 7'd0, spd_ceil: 7'd127};
            3: c = '{cruise_spd: 7'd60, prop_gain_half: 5'd20, deriv_gain_half: 5'd25,
                     steer_limit: 7'd100, spd_floor: 7'd100, spd_ceil: 7'd10};
            4: c = '{cruise_spd: 7'd127, prop_gain_half: 5'd31, deriv_gain_half: 5'd31,
                     steer_limit: 7'd0, spd_floor: 7'd127, spd_ceil: 7'd127};
            default: begin
                c.cruise_spd      = SPEED_W'($urandom_range(0, 127));
                c.prop_gain_half  = GAIN_W'($urandom_range(0, 31));
                c.deriv_gain_half = GAIN_W'($urandom_range(0, 31));
                c.steer_limit     = SPEED_W'($urandom_range(0, 127));
                c.spd_floor       = SPEED_W'($urandom_range(0, 40));
                c.spd_ceil        = SPEED_W'($urandom_range(30, 127));
            end
        endcase
        return c;
    endfunction

    // called at a clock edge; returns at the edge where the sample is taken
    task automatic send_sensor(input logic [SENSOR_W-1:0] pat, input logic typed,
                               input wheel_cmd_t typed_res);
        wheel_cmd_t c;
        if (!tx_quiet && $urandom_range(0, 9) < 3) begin
            s_tvalid <= 1'b0;
            repeat (idle_len()) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pat;
        do @(posedge aclk); while (!s_tready);
        c = steer_predict(pat);
        wheel_q.push_back(typed ? typed_res : c);
    endtask

    task automatic run_sequence(output int sent);
        logic [SENSOR_W-1:0] pat;
        int kind, r, reps;
        kind = $urandom_range(0, 9);
        sent = 0;
        if (kind <= 6) begin
            // a debounced run, mostly of known patterns
            pat = ($urandom_range(0, 4) == 0) ? SENSOR_W'($urandom_range(0, 255))
                                               : known_pattern();
            r = $urandom_range(0, 9);
            reps = (r < 6) ? 3 : (r < 8) ? $urandom_range(4, 7) : $urandom_range(1, 2);
            repeat (reps) begin
                send_sensor(pat, 1'b0, NO_CHECK);
                sent++;
            end
        end else if (kind <= 8) begin
            send_sensor(SENSOR_W'($urandom_range(0, 255)), 1'b0, NO_CHECK);
            sent = 1;
        end else begin
            // run cut short by a glitch on one sensor
            pat = known_pattern();
            send_sensor(pat, 1'b0, NO_CHECK);
            send_sensor(pat, 1'b0, NO_CHECK);
            send_sensor(pat ^ (SENSOR_W'(1) << $urandom_range(0, 7)), 1'b0, NO_CHECK);
            sent = 3;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (wheel_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_cfg(input cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CRUISE_SPD;
        cfg_wdata <= c.cruise_spd;
        @(posedge aclk);
        cfg_index <= CFG_PROP_GAIN;
        cfg_wdata <= CFG_DATA_W'(c.prop_gain_half);
        @(posedge aclk);
        cfg_index <= CFG_DERIV_GAIN;
        cfg_wdata <= CFG_DATA_W'(c.deriv_gain_half);
        @(posedge aclk);
        cfg_index <= CFG_STEER_LIMIT;
        cfg_wdata <= c.steer_limit;
        @(posedge aclk);
        cfg_index <= CFG_SPD_FLOOR;
        cfg_wdata <= c.spd_floor;
        @(posedge aclk);
        cfg_index <= CFG_SPD_CEIL;
        cfg_wdata <= c.spd_ceil;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic check_field(input string tag, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        wheel_cmd_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(wheel_cmd_t)-1:0];
            if (wheel_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected, got %h", $time, m_tdata);
                fail_cnt++;
            end else begin
                want = wheel_q.pop_front();
                check_field("left_cmd", want.left, got.left);
                check_field("right_cmd", want.right, got.right);
                check_field("line_error", want.err, got.err);
                check_field("steer", want.steer, got.steer);
                check_field("padding", want.pad, got.pad);
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready <= 1'b0;
        end else if (rx_quiet || $urandom_range(0, 9) >= 3) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            rx_stall_left <= idle_len() - 1;
        end
    end

    // one long receiver hold-off so the block fills and stalls its input
    initial begin
        wait (hold_req);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        int n, sent;
        cur_cfg = '{cruise_spd: RST_CRUISE_SPD, prop_gain_half: RST_PROP_GAIN,
                    deriv_gain_half: RST_DERIV_GAIN, steer_limit: RST_STEER_LIMIT,
                    spd_floor: RST_SPD_FLOOR, spd_ceil: RST_SPD_CEIL};
        last_pat   = '0;
        repeat_cnt = '0;
        hold_err   = 0;
        pd_err     = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_sensor(dir_tab[i].pat, dir_tab[i].typed, dir_tab[i].res);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            program_cfg(phase_cfg(ph));
            tx_quiet = (ph == 0) || (ph % 3 == 2);
            rx_quiet = (ph % 3 == 2);
            if (ph == 0) hold_req = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS) begin
                run_sequence(sent);
                n += sent;
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/lfs_pkg.sv
sv/lfs_track.sv
sv/lfs_steer.sv
sv/line_follow_steering_pd.sv
verif/testbench.sv
